// File: src/text_console_cursor_scroll_core_assert.svh
// assertion macros used by the console engine back end
// expects signals named clk and rst_n in the module that uses them
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_ASSERT_SVH

// condition must hold in the same cycle
`define TCCS_ASSERT_HOLDS(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tccs check failed");

// condition must hold in the next cycle
`define TCCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tccs check failed");

`endif

// File: src/tccs_pkg.sv
// types and constants shared by the console engine modules
// no dependencies
package tccs_pkg;

    // request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_MOVE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // control characters
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;

    localparam logic [7:0]  BLANK_CHAR = 8'h20;
    localparam logic [7:0]  COLOR_RST  = 8'h0F;
    localparam logic [15:0] CELL_RST   = 16'h0F20;

    // classified command
    typedef enum logic [3:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_RETURN,
        OP_TAB,
        OP_BACKSP,
        OP_MOVE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } tccs_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_REPORT,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR
    } tccs_state_t;

    typedef struct packed {
        tccs_op_t   op;
        logic [7:0] char_code;
        logic [7:0] target_row;
        logic [7:0] target_col;
    } tccs_cmd_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [4:0]  row_after;
        logic [6:0]  col_after;
        logic [15:0] cell_data;
        logic        cell_valid;
    } tccs_res_t;

endpackage

// File: src/tccs_ram.sv
// generic single write, single read memory with registered read data
// no dependencies
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/tccs_front.sv
// front end: accepts requests, classifies them and holds them in a short queue
// depends on tccs_pkg
module tccs_front
    import tccs_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] req_type,
    input  logic [7:0] char_code,
    input  logic [7:0] target_row,
    input  logic [7:0] target_col,
    input  logic       init_busy,
    output logic       cmd_valid,
    output tccs_cmd_t  cmd,
    input  logic       cmd_pop
);

    tccs_cmd_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    logic       in_range;
    tccs_cmd_t  cls;

    assign in_range = (target_row < 8'(ROWS)) && (target_col < 8'(COLS));

    // classify the request
    always_comb
    begin
        cls.char_code  = char_code;
        cls.target_row = target_row;
        cls.target_col = target_col;
        cls.op         = OP_NOP;
        unique case (req_type)
            REQ_PUT:
            begin
                unique case (char_code)
                    CH_NEWLINE:   cls.op = OP_NEWLINE;
                    CH_RETURN:    cls.op = OP_RETURN;
                    CH_TAB:       cls.op = OP_TAB;
                    CH_BACKSPACE: cls.op = OP_BACKSP;
                    default:      cls.op = OP_PRINT;
                endcase
            end
            REQ_MOVE:  cls.op = in_range ? OP_MOVE : OP_NOP;
            REQ_CLEAR: cls.op = OP_CLEAR;
            REQ_READ:  cls.op = in_range ? OP_READ : OP_NOP;
            default:   cls.op = OP_NOP;
        endcase
    end

    assign full      = init_busy || (count_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(accept) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// File: src/tccs_back.sv
// back end: cursor, screen memory sequencer and result queue
// depends on tccs_pkg, tccs_ram and the assertion macro header
`include "text_console_cursor_scroll_core_assert.svh"

module tccs_back
    import tccs_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  text_color,
    input  logic        cmd_valid,
    input  tccs_cmd_t   cmd,
    output logic        cmd_pop,
    output logic        init_busy,
    output logic        empty,
    input  logic        pop,
    output tccs_res_t   res
);

    localparam int NCELLS = ROWS * COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int RW     = $clog2(ROWS + 1);
    localparam int CW     = $clog2(COLS + 1);
    localparam int N_COPY = (ROWS - 1) * COLS;
    localparam int LAST   = NCELLS - 1;

    tccs_state_t   state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          hit_reg, hit_next;

    tccs_res_t     res_q_reg [2];
    logic          res_wr_reg, res_rd_reg;
    logic [1:0]    res_count_reg;
    logic          res_push, res_pop;
    tccs_res_t     res_new;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic          start;
    logic          need_scroll;
    logic          cnt_last;
    logic [15:0]   blank;
    logic [31:0]   cur_lin, rd_lin, copy_src, pos32, row32, col32;
    logic [RW-1:0] row_inc, eff_row;
    logic [CW-1:0] col_inc, eff_col;
    logic [CW:0]   tab_sum;
    logic          eff_we;
    logic [AW-1:0] eff_waddr;
    logic [15:0]   eff_wdata;

    assign blank     = {text_color, BLANK_CHAR};
    assign start     = (state_reg == ST_IDLE) && cmd_valid && (res_count_reg != 2'd2);
    assign cnt_last  = (cnt_reg == AW'(LAST));
    assign init_busy = (state_reg == ST_INIT);

    assign cur_lin  = 32'(row_reg) * 32'(COLS) + 32'(col_reg);
    assign rd_lin   = 32'(cmd.target_row[RW-1:0]) * 32'(COLS)
                    + 32'(cmd.target_col[CW-1:0]);
    assign copy_src = 32'(cnt_reg) + 32'(COLS);
    assign row_inc  = row_reg + RW'(1);
    assign col_inc  = col_reg + CW'(1);
    assign tab_sum  = (CW+1)'(col_reg) + (CW+1)'(4);

    // effect of the command at the head of the queue
    always_comb
    begin
        eff_row   = row_reg;
        eff_col   = col_reg;
        eff_we    = 1'b0;
        eff_waddr = cur_lin[AW-1:0];
        eff_wdata = {text_color, cmd.char_code};
        unique case (cmd.op)
            OP_PRINT:
            begin
                eff_we = 1'b1;
                if (col_inc == CW'(COLS))
                begin
                    eff_col = '0;
                    eff_row = row_inc;
                end
                else
                begin
                    eff_col = col_inc;
                end
            end
            OP_NEWLINE:
            begin
                eff_row = row_inc;
                eff_col = '0;
            end
            OP_RETURN:
            begin
                eff_col = '0;
            end
            OP_TAB:
            begin
                // round down to a multiple of four
                if ({tab_sum[CW:2], 2'b00} >= (CW+1)'(COLS))
                begin
                    eff_col = '0;
                    eff_row = row_inc;
                end
                else
                begin
                    eff_col = CW'({tab_sum[CW:2], 2'b00});
                end
            end
            OP_BACKSP:
            begin
                if (col_reg != '0)
                begin
                    eff_col   = col_reg - CW'(1);
                    eff_we    = 1'b1;
                    eff_waddr = cur_lin[AW-1:0] - AW'(1);
                    eff_wdata = blank;
                end
            end
            OP_MOVE:
            begin
                eff_row = cmd.target_row[RW-1:0];
                eff_col = cmd.target_col[CW-1:0];
            end
            OP_CLEAR:
            begin
                eff_row = '0;
                eff_col = '0;
            end
            default:
            begin
                eff_row = row_reg;
            end
        endcase
    end

    assign need_scroll = (eff_row == RW'(ROWS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:   state_next = cnt_last ? ST_IDLE : ST_INIT;
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd.op == OP_CLEAR)
                        state_next = ST_CLEAR;
                    else if (need_scroll)
                        state_next = ST_SCROLL;
                    else
                        state_next = ST_REPORT;
                end
            end
            ST_SCROLL: state_next = (cnt_reg == AW'(N_COPY)) ? ST_BLANK : ST_SCROLL;
            ST_BLANK:  state_next = cnt_last ? ST_REPORT : ST_BLANK;
            ST_CLEAR:  state_next = cnt_last ? ST_REPORT : ST_CLEAR;
            ST_REPORT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        cnt_next  = cnt_reg;
        hit_next  = hit_reg;
        cmd_pop   = 1'b0;
        res_push  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = blank;
        ram_re    = 1'b0;
        ram_raddr = rd_lin[AW-1:0];
        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = CELL_RST;
                cnt_next  = cnt_last ? '0 : cnt_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_pop   = 1'b1;
                    cnt_next  = '0;
                    hit_next  = (cmd.op == OP_READ);
                    ram_re    = (cmd.op == OP_READ);
                    ram_we    = eff_we;
                    ram_waddr = eff_waddr;
                    ram_wdata = eff_wdata;
                    row_next  = need_scroll ? RW'(ROWS - 1) : eff_row;
                    col_next  = eff_col;
                end
            end
            ST_SCROLL:
            begin
                // read one row below, write the cell read in the previous cycle
                ram_re    = (cnt_reg != AW'(N_COPY));
                ram_raddr = ram_re ? copy_src[AW-1:0] : '0;
                ram_we    = (cnt_reg != '0);
                ram_waddr = cnt_reg - AW'(1);
                ram_wdata = ram_rdata;
                cnt_next  = (cnt_reg == AW'(N_COPY)) ? cnt_reg : cnt_reg + AW'(1);
            end
            ST_BLANK, ST_CLEAR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + AW'(1);
            end
            ST_REPORT:
            begin
                res_push = 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
        end
    end

    tccs_ram #(
        .WIDTH (16),
        .DEPTH (NCELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result queue
    assign pos32 = cur_lin;
    assign row32 = 32'(row_reg);
    assign col32 = 32'(col_reg);

    always_comb
    begin
        res_new.cursor_pos = pos32[10:0];
        res_new.row_after  = row32[4:0];
        res_new.col_after  = col32[6:0];
        res_new.cell_data  = hit_reg ? ram_rdata : 16'h0000;
        res_new.cell_valid = hit_reg;
    end

    assign empty   = (res_count_reg == 2'd0);
    assign res_pop = pop && !empty;
    assign res     = res_q_reg[res_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg    <= 1'b0;
            res_rd_reg    <= 1'b0;
            res_count_reg <= 2'd0;
        end
        else
        begin
            res_wr_reg    <= res_push ? !res_wr_reg : res_wr_reg;
            res_rd_reg    <= res_pop ? !res_rd_reg : res_rd_reg;
            res_count_reg <= res_count_reg + 2'(res_push) - 2'(res_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_q_reg[res_wr_reg] <= res_new;
        end
    end

    `TCCS_ASSERT_HOLDS(a_row_in_range, 1'b1, row_reg < RW'(ROWS))
    `TCCS_ASSERT_HOLDS(a_report_has_room, state_reg == ST_REPORT, res_count_reg != 2'd2)
    `TCCS_ASSERT_HOLDS(a_pop_only_idle, cmd_pop, state_reg == ST_IDLE && cmd_valid)
    `TCCS_ASSERT_NEXT(a_copy_then_blank,
        state_reg == ST_SCROLL && cnt_reg == AW'(N_COPY),
        state_reg == ST_BLANK && cnt_reg == AW'(N_COPY))

endmodule

// File: src/text_console_cursor_scroll_core.sv
// top level of the text console engine: colour register, front end, back end
// depends on tccs_pkg, tccs_front, tccs_back
//
// text console engine over a ROWS x COLS screen memory of 16-bit cells
// (attribute in bits 15..8, character in bits 7..0). requests enter through a
// queue-style port (push/full) and every request gives exactly one result on a
// queue-style port (empty/pop) holding the cursor after the request and, for
// an in-range cell read, the cell contents. after reset the screen memory is
// swept to blank, one cell a cycle, while full stays high; colour writes are
// still taken during that sweep. a put, move, read or ignored request first
// issues the memory access and updates the cursor, then reports. a clear
// blanks every cell before its report, and a put that runs past the last row
// scrolls before its report: the scroll copies every row up through the
// single write port of the screen memory one cell a cycle and then blanks the
// last row. a two-entry request queue and a two-entry result queue let the
// host side keep pushing and popping while the engine works. the colour
// register must only be written while no transaction is outstanding.
module text_console_cursor_scroll_core
    import tccs_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [7:0]  char_code,
    input  logic [7:0]  target_row,
    input  logic [7:0]  target_col,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [10:0] cursor_pos,
    output logic [4:0]  cursor_row_out,
    output logic [6:0]  cursor_col_out,
    output logic [15:0] cell_data,
    output logic        cell_valid,
    // colour register
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    logic [7:0] text_color_reg;
    logic       cmd_valid;
    tccs_cmd_t  cmd;
    logic       cmd_pop;
    logic       init_busy;
    tccs_res_t  res;

    // attribute used for written and blanked cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= COLOR_RST;
        end
        else if (cfg_wr_en)
        begin
            text_color_reg <= cfg_wr_data;
        end
    end

    // classification and request queue
    tccs_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .char_code  (char_code),
        .target_row (target_row),
        .target_col (target_col),
        .init_busy  (init_busy),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    // cursor, screen memory sequencing and result queue
    tccs_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_color (text_color_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .init_busy  (init_busy),
        .empty      (empty),
        .pop        (pop),
        .res        (res)
    );

    // oldest result on the ports
    assign cursor_pos     = res.cursor_pos;
    assign cursor_row_out = res.row_after;
    assign cursor_col_out = res.col_after;
    assign cell_data      = res.cell_data;
    assign cell_valid     = res.cell_valid;

endmodule

// File: sim/text_console_cursor_scroll_core_tb.sv
// self-checking testbench for the text console engine, queue-style ports on both sides
// depends on tccs_pkg and text_console_cursor_scroll_core; a directed table then random phases
// each with its own text colour, every result checked against the directed table or a local screen/cursor predictor
module text_console_cursor_scroll_core_tb;
    import tccs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int NCELLS      = ROWS * COLS;
    localparam int NDIR        = 26;
    localparam int NPHASE      = 6;
    localparam int PHASE_ITEMS = 155;
    // receiver hold-off long enough to fill both two-entry queues and stall the input
    localparam int HOLD_CYCLES = 400;
    // no transaction for this long means the block has hung; a clear or scroll
    // plus the longest hold-off sits well inside it
    localparam int STUCK_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [7:0]  target_row;
    logic [7:0]  target_col;
    logic        empty;
    logic        pop;
    logic [10:0] cursor_pos;
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
    logic [15:0] cell_data;
    logic        cell_valid;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    text_console_cursor_scroll_core #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .char_code      (char_code),
        .target_row     (target_row),
        .target_col     (target_col),
        .empty          (empty),
        .pop            (pop),
        .cursor_pos     (cursor_pos),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out),
        .cell_data      (cell_data),
        .cell_valid     (cell_valid),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: own copy of the screen, cursor and colour register
    // ------------------------------------------------------------------
    logic [15:0] screen_model [NCELLS];
    logic [4:0]  row_model;
    logic [6:0]  col_model;
    logic [7:0]  color_model;

    // cursor reports still owed by the block, oldest first
    tccs_res_t   pending_reports [$];
    int          errors = 0;

    // pacing controls shared by the sender and receiver processes
    bit          steady  = 1'b0;   // phase with no idling at all
    bit          hold_now = 1'b0;  // receiver long hold-off requested

    // directed table: rows with a typed result are checked against it,
    // the others against the predictor
    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  ch;
        logic [7:0]  trow;
        logic [7:0]  tcol;
        logic        typed;
        logic [10:0] e_pos;
        logic [4:0]  e_row;
        logic [6:0]  e_col;
        logic [15:0] e_data;
        logic        e_valid;
    } directed_row_t;

    directed_row_t directed_tab [NDIR] = '{
        // reads straight after reset: blank cells at both corners
        '{REQ_READ,  8'h00,        8'd0,   8'd0,   1'b1, 11'd0,    5'd0,  7'd0,  CELL_RST, 1'b1},
        '{REQ_READ,  8'h00,        8'd24,  8'd79,  1'b1, 11'd0,    5'd0,  7'd0,  CELL_RST, 1'b1},
        // reads outside the screen give nothing
        '{REQ_READ,  8'h00,        8'd25,  8'd0,   1'b1, 11'd0,    5'd0,  7'd0,  16'h0000, 1'b0},
        '{REQ_READ,  8'h00,        8'd0,   8'd80,  1'b1, 11'd0,    5'd0,  7'd0,  16'h0000, 1'b0},
        '{REQ_READ,  8'hFF,        8'd255, 8'd255, 1'b1, 11'd0,    5'd0,  7'd0,  16'h0000, 1'b0},
        // printable, zero and top-bit characters
        '{REQ_PUT,   8'h41,        8'd0,   8'd0,   1'b1, 11'd1,    5'd0,  7'd1,  16'h0000, 1'b0},
        '{REQ_PUT,   8'h00,        8'd0,   8'd0,   1'b1, 11'd2,    5'd0,  7'd2,  16'h0000, 1'b0},
        '{REQ_PUT,   8'hFF,        8'd0,   8'd0,   1'b1, 11'd3,    5'd0,  7'd3,  16'h0000, 1'b0},
        // the top-bit byte must not leak into the attribute
        '{REQ_READ,  8'h00,        8'd0,   8'd2,   1'b1, 11'd3,    5'd0,  7'd3,  16'h0FFF, 1'b1},
        '{REQ_PUT,   CH_TAB,       8'd0,   8'd0,   1'b1, 11'd4,    5'd0,  7'd4,  16'h0000, 1'b0},
        '{REQ_PUT,   CH_BACKSPACE, 8'd0,   8'd0,   1'b1, 11'd3,    5'd0,  7'd3,  16'h0000, 1'b0},
        '{REQ_READ,  8'h00,        8'd0,   8'd3,   1'b1, 11'd3,    5'd0,  7'd3,  CELL_RST, 1'b1},
        '{REQ_PUT,   CH_RETURN,    8'd0,   8'd0,   1'b1, 11'd0,    5'd0,  7'd0,  16'h0000, 1'b0},
        // backspace at column 0 does nothing
        '{REQ_PUT,   CH_BACKSPACE, 8'd0,   8'd0,   1'b1, 11'd0,    5'd0,  7'd0,  16'h0000, 1'b0},
        '{REQ_PUT,   CH_NEWLINE,   8'd0,   8'd0,   1'b1, 11'd80,   5'd1,  7'd0,  16'h0000, 1'b0},
        // moves out of range are ignored; then a move to the last cell
        '{REQ_MOVE,  8'h00,        8'd255, 8'd0,   1'b1, 11'd80,   5'd1,  7'd0,  16'h0000, 1'b0},
        '{REQ_MOVE,  8'h00,        8'd0,   8'd255, 1'b1, 11'd80,   5'd1,  7'd0,  16'h0000, 1'b0},
        '{REQ_MOVE,  8'h00,        8'd24,  8'd79,  1'b1, 11'd1999, 5'd24, 7'd79, 16'h0000, 1'b0},
        // character in the last cell wraps and scrolls
        '{REQ_PUT,   8'h5A,        8'd0,   8'd0,   1'b1, 11'd1920, 5'd24, 7'd0,  16'h0000, 1'b0},
        '{REQ_READ,  8'h00,        8'd23,  8'd79,  1'b1, 11'd1920, 5'd24, 7'd0,  16'h0F5A, 1'b1},
        // tab and newline off the last row both scroll
        '{REQ_MOVE,  8'h00,        8'd24,  8'd76,  1'b0, 11'd0,    5'd0,  7'd0,  16'h0000, 1'b0},
        '{REQ_PUT,   CH_TAB,       8'd0,   8'd0,   1'b0, 11'd0,    5'd0,  7'd0,  16'h0000, 1'b0},
        '{REQ_PUT,   CH_NEWLINE,   8'd0,   8'd0,   1'b0, 11'd0,    5'd0,  7'd0,  16'h0000, 1'b0},
        '{REQ_READ,  8'h00,        8'd0,   8'd0,   1'b0, 11'd0,    5'd0,  7'd0,  16'h0000, 1'b0},
        '{REQ_CLEAR, 8'h00,        8'd0,   8'd0,   1'b1, 11'd0,    5'd0,  7'd0,  16'h0000, 1'b0},
        '{REQ_READ,  8'h00,        8'd23,  8'd79,  1'b1, 11'd0,    5'd0,  7'd0,  CELL_RST, 1'b1}
    };

    // scroll every row up one and blank the last row
    function automatic void scroll_screen();
        for (int i = 0; i < (ROWS - 1) * COLS; i++)
            screen_model[i] = screen_model[i + COLS];
        for (int i = (ROWS - 1) * COLS; i < NCELLS; i++)
            screen_model[i] = {color_model, BLANK_CHAR};
        row_model = 5'(ROWS - 1);
    endfunction

    // apply one request to the predictor and return the cursor report it owes
    function automatic tccs_res_t console_predict(input logic [1:0] req, input logic [7:0] ch,
                                                   input logic [7:0] trow,
                                                   input logic [7:0] tcol);
        tccs_res_t rep;
        int        idx;
        bit        on_screen;
        rep       = '0;
        on_screen = (int'(trow) < ROWS) && (int'(tcol) < COLS);
        case (req)
            REQ_PUT:
            begin
                case (ch)
                    CH_NEWLINE:
                    begin
                        row_model = row_model + 5'd1;
                        col_model = '0;
                    end
                    CH_RETURN:
                        col_model = '0;
                    CH_TAB:
                    begin
                        col_model = (col_model + 7'd4) & ~7'd3;
                        if (int'(col_model) >= COLS)
                        begin
                            col_model = '0;
                            row_model = row_model + 5'd1;
                        end
                    end
                    CH_BACKSPACE:
                    begin
                        if (col_model != 0)
                        begin
                            col_model = col_model - 7'd1;
                            screen_model[int'(row_model) * COLS + int'(col_model)] =
                                {color_model, BLANK_CHAR};
                        end
                    end
                    default:
                    begin
                        idx = int'(row_model) * COLS + int'(col_model);
                        if (idx < NCELLS)
                            screen_model[idx] = {color_model, ch};
                        col_model = col_model + 7'd1;
                        if (int'(col_model) >= COLS)
                        begin
                            col_model = '0;
                            row_model = row_model + 5'd1;
                        end
                    end
                endcase
                if (int'(row_model) >= ROWS)
                    scroll_screen();
            end
            REQ_MOVE:
            begin
                if (on_screen)
                begin
                    row_model = 5'(trow);
                    col_model = 7'(tcol);
                end
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < NCELLS; i++)
                    screen_model[i] = {color_model, BLANK_CHAR};
                row_model = '0;
                col_model = '0;
            end
            default:
            begin
                if (on_screen)
                begin
                    rep.cell_data  = screen_model[int'(trow) * COLS + int'(tcol)];
                    rep.cell_valid = 1'b1;
                end
            end
        endcase
        rep.cursor_pos = 11'(int'(row_model) * COLS + int'(col_model));
        rep.row_after  = row_model;
        rep.col_after  = col_model;
        return rep;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one request until accepted, then log what the block owes for it
    task automatic offer_request(input logic [1:0] req, input logic [7:0] ch,
                                 input logic [7:0] trow, input logic [7:0] tcol,
                                 input bit typed, input tccs_res_t typed_rep);
        tccs_res_t predicted;
        @(negedge clk);
        push       <= 1'b1;
        req_type   <= req;
        char_code  <= ch;
        target_row <= trow;
        target_col <= tcol;
        @(posedge clk);
        while (full)
            @(posedge clk);
        // predictor always runs so that its state follows the block
        predicted = console_predict(req, ch, trow, tcol);
        pending_reports.push_back(typed ? typed_rep : predicted);
    endtask

    // sender idle after a transaction; push stays high when there is no gap
    task automatic sender_gap();
        int gap;
        gap = (steady || hold_now) ? 0 : gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // colour register write, only with nothing outstanding
    task automatic write_color(input logic [7:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        color_model = value;
    endtask

    // ------------------------------------------------------------------
    // receiver: random pops, one long hold-off on request, field checks
    // ------------------------------------------------------------------
    initial
    begin
        int        stall;
        tccs_res_t want;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_now)
            begin
                // long hold-off counted here while the sender keeps pushing
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_now = 1'b0;
            end
            else
            begin
                if (stall > 0)
                begin
                    pop   <= 1'b0;
                    stall = stall - 1;
                end
                else
                    pop <= 1'b1;
                @(posedge clk);
                if (pop && !empty)
                begin
                    if (pending_reports.size() == 0)
                    begin
                        $error("result transaction with no request waiting for it");
                        errors++;
                    end
                    else
                    begin
                        want = pending_reports.pop_front();
                        if (cursor_pos !== want.cursor_pos)
                        begin
                            $error("cursor_pos expected %0d got %0d", want.cursor_pos,
                                   cursor_pos);
                            errors++;
                        end
                        if (cursor_row_out !== want.row_after)
                        begin
                            $error("cursor_row_out expected %0d got %0d", want.row_after,
                                   cursor_row_out);
                            errors++;
                        end
                        if (cursor_col_out !== want.col_after)
                        begin
                            $error("cursor_col_out expected %0d got %0d", want.col_after,
                                   cursor_col_out);
                            errors++;
                        end
                        if (cell_data !== want.cell_data)
                        begin
                            $error("cell_data expected %h got %h", want.cell_data, cell_data);
                            errors++;
                        end
                        if (cell_valid !== want.cell_valid)
                        begin
                            $error("cell_valid expected %0d got %0d", want.cell_valid,
                                   cell_valid);
                            errors++;
                        end
                    end
                    stall = steady ? 0 : gap_len();
                end
            end
        end
    end

    // watchdog: too long with no transaction on either side
    int stuck_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence: reset, directed table, random phases per colour
    // ------------------------------------------------------------------
    initial
    begin
        int          ph;
        int          k;
        int          sel;
        logic [1:0]  req;
        logic [7:0]  ch;
        logic [7:0]  trow;
        logic [7:0]  tcol;
        logic [7:0]  phase_color;
        tccs_res_t   typed_rep;

        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        req_type    = REQ_PUT;
        char_code   = '0;
        target_row  = '0;
        target_col  = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;

        for (int i = 0; i < NCELLS; i++)
            screen_model[i] = CELL_RST;
        row_model   = '0;
        col_model   = '0;
        color_model = COLOR_RST;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // colour is taken during the blanking sweep; keep the reset value here
        write_color(COLOR_RST);

        // directed part
        for (k = 0; k < NDIR; k++)
        begin
            typed_rep.cursor_pos = directed_tab[k].e_pos;
            typed_rep.row_after  = directed_tab[k].e_row;
            typed_rep.col_after  = directed_tab[k].e_col;
            typed_rep.cell_data  = directed_tab[k].e_data;
            typed_rep.cell_valid = directed_tab[k].e_valid;
            offer_request(directed_tab[k].req, directed_tab[k].ch, directed_tab[k].trow,
                          directed_tab[k].tcol, directed_tab[k].typed, typed_rep);
            sender_gap();
        end
        @(negedge clk);
        push <= 1'b0;

        // random phases, each starting from an idle block with a fresh colour
        for (ph = 0; ph < NPHASE; ph++)
        begin
            // sender pauses until every owed report has come back
            while (pending_reports.size() != 0)
                @(posedge clk);
            case (ph)
                0:       phase_color = 8'h00;
                1:       phase_color = 8'hFF;
                2:       phase_color = 8'h5A;
                default: phase_color = 8'($urandom_range(0, 255));
            endcase
            write_color(phase_color);
            steady = (ph == 2) || ($urandom_range(0, 3) == 0);

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 0 && k == 20)
                    hold_now = 1'b1;
                sel  = $urandom_range(0, 99);
                ch   = 8'($urandom_range(0, 255));
                trow = 8'($urandom_range(0, 255));
                tcol = 8'($urandom_range(0, 255));
                if (sel < 55)
                begin
                    // puts, with control characters weighted up
                    req = REQ_PUT;
                    sel = $urandom_range(0, 99);
                    if (sel < 14)
                        ch = CH_NEWLINE;
                    else if (sel < 20)
                        ch = CH_TAB;
                    else if (sel < 25)
                        ch = CH_RETURN;
                    else if (sel < 33)
                        ch = CH_BACKSPACE;
                end
                else if (sel < 72)
                begin
                    // moves, mostly on screen and often onto the last row to provoke scrolls
                    req = REQ_MOVE;
                    if ($urandom_range(0, 9) < 7)
                    begin
                        trow = ($urandom_range(0, 2) == 0) ? 8'(ROWS - 1)
                                                           : 8'($urandom_range(0, ROWS - 1));
                        tcol = 8'($urandom_range(0, COLS - 1));
                    end
                end
                else if (sel < 98)
                begin
                    req = REQ_READ;
                    if ($urandom_range(0, 9) < 8)
                    begin
                        trow = 8'($urandom_range(0, ROWS - 1));
                        tcol = 8'($urandom_range(0, COLS - 1));
                    end
                end
                else
                    req = REQ_CLEAR;
                offer_request(req, ch, trow, tcol, 1'b0, '0);
                sender_gap();
            end
            @(negedge clk);
            push <= 1'b0;
        end

        // drain, then allow the reporting latency before the verdict
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
